// File: design/isaac_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package isaac_pkg;
    localparam int TABLE_WORDS_DEF = 32;
    localparam logic [31:0] GOLDEN_WORD = 32'h9e3779b9;

    localparam logic [1:0] REQ_SEED = 2'd0;
    localparam logic [1:0] REQ_INIT = 2'd1;
    localparam logic [1:0] REQ_NEXT = 2'd2;
    localparam logic [1:0] REQ_RSVD = 2'd3;   // unused code, ignored

    // datapath operations issued by the controller
    typedef enum logic [2:0] {
        OP_NONE    = 3'd0,
        OP_SEED    = 3'd1,
        OP_INIT    = 3'd2,
        OP_SCRAM   = 3'd3,
        OP_MIXLOAD = 3'd4,
        OP_MIXSTEP = 3'd5,
        OP_SHUF    = 3'd6,
        OP_READ    = 3'd7
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   first;    // first cycle of an operation group
    } dp_cmd_t;

    typedef struct packed {
        logic done;       // current multi-cycle operation finished
        logic exhausted;  // read position at end of table
    } dp_stat_t;
endpackage
`default_nettype wire

// File: design/isaac_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module isaac_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         req_type,
    input  wire logic               out_valid,
    input  wire logic               out_ready,
    input  wire isaac_pkg::dp_stat_t stat,
    output isaac_pkg::dp_cmd_t      cmd
);
    import isaac_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_SCRAM = 8'b00000010,
        S_MIX1  = 8'b00000100,
        S_MIX2  = 8'b00001000,
        S_SHUF  = 8'b00010000,
        S_CHK   = 8'b00100000,
        S_NSHUF = 8'b01000000,
        S_READ  = 8'b10000000
    } state_t;

    state_t state_reg, state_next;
    logic   first_reg, first_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        first_next = 1'b0;
        cmd.op     = OP_NONE;
        cmd.first  = first_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (req_type == REQ_SEED)
                        cmd.op = OP_SEED;
                    else if (req_type == REQ_INIT)
                    begin
                        cmd.op = OP_INIT;
                        state_next = S_SCRAM;
                        first_next = 1'b1;
                    end
                    else if (req_type == REQ_NEXT)
                        state_next = S_CHK;
                end
            end
            S_SCRAM:
            begin
                cmd.op = OP_SCRAM;
                if (stat.done)
                begin
                    state_next = S_MIX1;
                    first_next = 1'b1;
                end
            end
            S_MIX1, S_MIX2:
            begin
                cmd.op = OP_MIXSTEP;
                if (stat.done)
                begin
                    state_next = (state_reg == S_MIX1) ? S_MIX2 : S_SHUF;
                    first_next = 1'b1;
                end
            end
            S_SHUF, S_NSHUF:
            begin
                cmd.op = OP_SHUF;
                if (stat.done)
                begin
                    state_next = (state_reg == S_SHUF) ? S_IDLE : S_READ;
                    first_next = 1'b1;
                end
            end
            S_CHK:
            begin
                if (!out_valid || out_ready)
                begin
                    if (stat.exhausted)
                    begin
                        state_next = S_NSHUF;
                        first_next = 1'b1;
                    end
                    else
                        state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.op = OP_READ;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            first_reg <= first_next;
        end
    end
endmodule
`default_nettype wire

// File: design/isaac_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module isaac_dp #(
    parameter int TABLE_WORDS = isaac_pkg::TABLE_WORDS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire isaac_pkg::dp_cmd_t cmd,
    input  wire logic [4:0]         seed_slot,
    input  wire logic [31:0]        seed_word,
    output isaac_pkg::dp_stat_t     stat,
    input  wire logic               out_ready,
    output logic                    out_valid,
    output logic [31:0]             random_word
);
    import isaac_pkg::*;

    localparam int AW = $clog2(TABLE_WORDS);
    localparam int GROUPS = TABLE_WORDS / 8;
    localparam int GW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam logic [AW-1:0] HALF = AW'(TABLE_WORDS / 2);
    localparam logic [AW-1:0] LAST = AW'(TABLE_WORDS - 1);

    // valid bits emulate the all-zero reset of the two stores
    logic [31:0] mm  [TABLE_WORDS];
    logic [31:0] rs  [TABLE_WORDS];
    logic [TABLE_WORDS-1:0] mm_vld_reg, rs_vld_reg;

    logic [31:0] v_reg [8];
    logic [31:0] a_reg, b_reg, rc_reg;
    logic [AW:0] pos_reg;

    logic [4:0]    step_reg;     // sub-step counter
    logic [AW-1:0] idx_reg;
    logic [GW-1:0] grp_reg;
    logic [31:0]   x_reg, y_reg;
    logic          done;
    logic          exhausted;

    logic [31:0] out_reg;
    logic        ov_reg;
    logic        rd_pend_reg;    // word read issued, lands in out_reg next cycle
    assign out_valid   = ov_reg;
    assign random_word = out_reg;
    assign exhausted   = (pos_reg >= (AW+1)'(TABLE_WORDS));
    assign stat.done      = done;
    assign stat.exhausted = exhausted;

    // one scramble step (of eight) on the working vector
    function automatic logic [31:0] sc_shift(input logic [2:0] k, input logic [31:0] w);
        logic [31:0] r;
        case (k)
            3'd0: r = w << 11;
            3'd1: r = w >> 2;
            3'd2: r = w << 8;
            3'd3: r = w >> 16;
            3'd4: r = w << 10;
            3'd5: r = w >> 4;
            3'd6: r = w << 8;
            default: r = w >> 9;
        endcase
        return r;
    endfunction

    logic [AW-1:0] rd_addr;
    logic [31:0]   rd_mm, rd_rs;
    logic [AW-1:0] gi;
    logic [2:0]    mk;           // scramble line during a mixing pass
    logic          mix2_reg;
    logic [31:0]   f;
    logic [31:0]   a_new;
    logic [31:0]   y_new;
    logic [31:0]   b_src;

    assign gi = AW'({grp_reg, 3'b000});
    assign mk = 3'(step_reg - 5'd9);

    always_comb
    begin
        done = 1'b0;
        unique case (cmd.op)
            OP_SCRAM:   done = (step_reg == 5'd31);
            OP_MIXSTEP: done = (step_reg == 5'd18) && (grp_reg == GW'(GROUPS - 1));
            OP_SHUF:    done = (step_reg == 5'd4) && (idx_reg == LAST);
            default:    done = 1'b0;
        endcase
    end

    // memory reads are registered: the read address is issued in the cycle before its data is used
    always_ff @(posedge clk)
    begin
        rd_mm <= mm_vld_reg[rd_addr] ? mm[rd_addr] : 32'd0;
        rd_rs <= rs_vld_reg[rd_addr] ? rs[rd_addr] : 32'd0;
    end

    always_comb
    begin
        case (idx_reg[1:0])
            2'd0: f = a_reg << 13;
            2'd1: f = a_reg >> 6;
            2'd2: f = a_reg << 2;
            default: f = a_reg >> 16;
        endcase
        a_new = (a_reg ^ f) + rd_mm;
        y_new = rd_mm + a_reg + b_reg;
    end

    // shuffle step 4 must see the entry written at step 3
    assign b_src = (y_reg[AW+9:10] == idx_reg) ? y_reg : rd_mm;

    // address selection per step; an exhausted store reads from entry 0
    always_comb
    begin
        rd_addr = exhausted ? '0 : pos_reg[AW-1:0];
        if (cmd.op == OP_MIXSTEP)
            rd_addr = gi + AW'(step_reg[2:0]);
        else if (cmd.op == OP_SHUF)
        begin
            case (step_reg)
                5'd0: rd_addr = idx_reg;
                5'd1: rd_addr = idx_reg + HALF;
                5'd2: rd_addr = x_reg[AW+1:2];
                default: rd_addr = y_new[AW+9:10];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mm_vld_reg <= '0;
            rs_vld_reg <= '0;
            a_reg <= '0;
            b_reg <= '0;
            rc_reg <= '0;
            pos_reg <= (AW+1)'(TABLE_WORDS);
            step_reg <= '0;
            idx_reg <= '0;
            grp_reg <= '0;
            x_reg <= '0;
            y_reg <= '0;
            ov_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
            mix2_reg <= 1'b0;
        end
        else
        begin
            if (rd_pend_reg)
                ov_reg <= 1'b1;
            else if (ov_reg && out_ready)
                ov_reg <= 1'b0;
            rd_pend_reg <= (cmd.op == OP_READ);
            unique case (cmd.op)
                OP_SEED:
                begin
                    if ({27'd0, seed_slot} < 32'(TABLE_WORDS))
                        rs_vld_reg[AW'(seed_slot)] <= 1'b1;
                end
                OP_INIT:
                begin
                    a_reg <= '0;
                    b_reg <= '0;
                    rc_reg <= '0;
                    step_reg <= '0;
                    mix2_reg <= 1'b0;
                    pos_reg <= (AW+1)'(TABLE_WORDS);
                end
                OP_SCRAM:
                    step_reg <= (step_reg == 5'd31) ? 5'd0 : step_reg + 5'd1;
                OP_MIXSTEP:
                begin
                    // steps 0..7 issue reads, 1..8 add, 9..16 scramble, 17 writes, 18 moves to the next group
                    if (cmd.first)
                    begin
                        step_reg <= 5'd1;
                        grp_reg <= '0;
                    end
                    else if (step_reg == 5'd18)
                    begin
                        step_reg <= '0;
                        if (grp_reg == GW'(GROUPS - 1))
                        begin
                            grp_reg <= '0;
                            mix2_reg <= 1'b1;
                        end
                        else
                            grp_reg <= grp_reg + GW'(1);
                    end
                    else
                        step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'd17)
                        mm_vld_reg[gi +: 8] <= 8'hff;
                end
                OP_SHUF:
                begin
                    if (cmd.first)
                    begin
                        rc_reg <= rc_reg + 32'd1;
                        b_reg <= b_reg + rc_reg + 32'd1;
                        idx_reg <= '0;
                        step_reg <= 5'd0;
                    end
                    else
                    begin
                        case (step_reg)
                            5'd0: step_reg <= 5'd1;
                            5'd1:
                            begin
                                x_reg <= rd_mm;
                                step_reg <= 5'd2;
                            end
                            5'd2:
                            begin
                                a_reg <= a_new;
                                step_reg <= 5'd3;
                            end
                            5'd3:
                            begin
                                y_reg <= y_new;
                                mm_vld_reg[idx_reg] <= 1'b1;
                                step_reg <= 5'd4;
                            end
                            default:
                            begin
                                b_reg <= b_src + x_reg;
                                rs_vld_reg[idx_reg] <= 1'b1;
                                step_reg <= 5'd0;
                                idx_reg <= idx_reg + AW'(1);
                            end
                        endcase
                    end
                end
                OP_READ:
                    pos_reg <= exhausted ? (AW+1)'(1) : pos_reg + (AW+1)'(1);
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_pend_reg)
            out_reg <= rd_rs;
        if (cmd.op == OP_SEED && {27'd0, seed_slot} < 32'(TABLE_WORDS))
            rs[AW'(seed_slot)] <= seed_word;
        if (cmd.op == OP_INIT)
            for (int k = 0; k < 8; k++)
                v_reg[k] <= GOLDEN_WORD;
        if (cmd.op == OP_SCRAM)
        begin
            // 32 steps = 4 scrambles of 8 steps
            v_reg[step_reg[2:0]] <= v_reg[step_reg[2:0]]
                ^ sc_shift(step_reg[2:0], v_reg[3'(step_reg[2:0] + 3'd1)]);
            v_reg[3'(step_reg[2:0] + 3'd3)] <= v_reg[3'(step_reg[2:0] + 3'd3)]
                + (v_reg[step_reg[2:0]]
                   ^ sc_shift(step_reg[2:0], v_reg[3'(step_reg[2:0] + 3'd1)]));
            v_reg[3'(step_reg[2:0] + 3'd1)] <= v_reg[3'(step_reg[2:0] + 3'd1)]
                + v_reg[3'(step_reg[2:0] + 3'd2)];
        end
        if (cmd.op == OP_MIXSTEP && !cmd.first)
        begin
            if (step_reg >= 5'd1 && step_reg <= 5'd8)
                v_reg[3'(step_reg - 5'd1)] <= v_reg[3'(step_reg - 5'd1)]
                    + (mix2_reg ? rd_mm : rd_rs);
            else if (step_reg >= 5'd9 && step_reg <= 5'd16)
            begin
                v_reg[mk] <= v_reg[mk] ^ sc_shift(mk, v_reg[3'(mk + 3'd1)]);
                v_reg[3'(mk + 3'd3)] <= v_reg[3'(mk + 3'd3)]
                    + (v_reg[mk] ^ sc_shift(mk, v_reg[3'(mk + 3'd1)]));
                v_reg[3'(mk + 3'd1)] <= v_reg[3'(mk + 3'd1)]
                    + v_reg[3'(mk + 3'd2)];
            end
            else if (step_reg == 5'd17)
                for (int k = 0; k < 8; k++)
                    mm[gi + AW'(k)] <= v_reg[k];
        end
        if (cmd.op == OP_SHUF && !cmd.first)
        begin
            if (step_reg == 5'd3)
                mm[idx_reg] <= y_new;
            if (step_reg == 5'd4)
            begin
                rs[idx_reg] <= b_src + x_reg;
            end
        end
    end
endmodule
`default_nettype wire

// File: design/isaac_random_generator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ISAAC 32-bit generator with 32-word tables by default. req_type 0 writes
// seed_word into the result store at seed_slot, 1 runs initialization (32
// scramble steps, two mixing passes and one shuffle before the next request
// can be taken), 2 returns the next random word on random_word. A next
// request reads a stored word directly when one is available, and runs the
// shuffle over all table entries first when the store is exhausted; the
// memory has a single read port. The output register lets the next request
// be accepted while a word still waits for out_ready.
module isaac_random_generator_core #(
    parameter int TABLE_WORDS = isaac_pkg::TABLE_WORDS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  req_type,
    input  wire logic [4:0]  seed_slot,
    input  wire logic [31:0] seed_word,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      random_word
);
    import isaac_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    isaac_ctrl u_ctrl (
        .clk, .rst_n, .in_valid, .in_ready, .req_type,
        .out_valid, .out_ready, .stat, .cmd
    );

    isaac_dp #(.TABLE_WORDS(TABLE_WORDS)) u_dp (
        .clk, .rst_n, .cmd, .seed_slot, .seed_word, .stat,
        .out_ready, .out_valid, .random_word
    );
endmodule
`default_nettype wire
